[src/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants
// Window type, control state codes and register indexes of the Sobel block.
// ----------------------------------------------------------------------------
package sem_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int HEIGHT_MAX    = 4096;
	localparam int WIDTH_RESET   = 1024;
	localparam int HEIGHT_RESET  = 1024;
	localparam int WREG_W        = 11;
	localparam int HREG_W        = 13;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 13;
	localparam int PIX_W         = 24;
	localparam int MAG_SAT       = 255;
	localparam int SQ_SAT        = 255 * 255 + 255;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

	typedef logic [PIX_W-1:0] pix_t;
	// win[row][col], row 0 is the oldest line, col 0 the leftmost column
	typedef logic [2:0][2:0][PIX_W-1:0] win_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRD,
		ST_PWB,
		ST_FRD,
		ST_MAG,
		ST_OUT
	} sem_state_t;

	typedef enum logic [1:0] {
		MP_IDLE,
		MP_SQ,
		MP_ITER,
		MP_FIN
	} sem_mph_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} mag_res_t;

endpackage

[src/sem_row_mem.sv]
// ----------------------------------------------------------------------------
// sem_row_mem: line store
// One entry per column holds the two previous rows of that column.
// ----------------------------------------------------------------------------
module sem_row_mem #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF,
	parameter int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [2*sem_pkg::PIX_W-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [2*sem_pkg::PIX_W-1:0] wr_data
);
	import sem_pkg::*;

	// Upper half: row two above, lower half: row above.
	logic [2*PIX_W-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/sem_mag.sv]
// ----------------------------------------------------------------------------
// sem_mag: Sobel magnitude unit
// Gradients, exact squared sum and a bit-serial rounded root for three channels.
// ----------------------------------------------------------------------------
module sem_mag (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sem_pkg::win_t     win,
	output logic              done,
	output sem_pkg::mag_res_t res
);
	import sem_pkg::*;

	sem_mph_t           ph_q;
	logic signed [10:0] gx_q [3];
	logic signed [10:0] gy_q [3];
	logic        [20:0] s_q  [3];
	logic        [7:0]  n_q  [3];
	logic        [2:0]  k_q;
	logic               done_q;
	logic signed [10:0] gx_c [3];
	logic signed [10:0] gy_c [3];
	logic        [7:0]  mag_c [3];

	// Channel 0 (red) sits in the lowest byte of a pixel.
	function automatic logic signed [10:0] px(input win_t w, input int i, input int j,
		input int ch);
		logic [7:0] v;
		v = w[i][j][8*ch +: 8];
		return signed'({3'b000, v});
	endfunction

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			gx_c[ch] = (px(win, 0, 2, ch) + (px(win, 1, 2, ch) <<< 1) + px(win, 2, 2, ch))
				- (px(win, 0, 0, ch) + (px(win, 1, 0, ch) <<< 1) + px(win, 2, 0, ch));
			gy_c[ch] = (px(win, 2, 0, ch) + (px(win, 2, 1, ch) <<< 1) + px(win, 2, 2, ch))
				- (px(win, 0, 0, ch) + (px(win, 0, 1, ch) <<< 1) + px(win, 0, 2, ch));
			if (s_q[ch] > 21'(SQ_SAT)) begin
				mag_c[ch] = 8'(MAG_SAT);
			end else if (s_q[ch] == '0) begin
				mag_c[ch] = '0;
			end else begin
				mag_c[ch] = n_q[ch] + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= MP_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				MP_IDLE: if (start) ph_q <= MP_SQ;
				MP_SQ:   ph_q <= MP_ITER;
				MP_ITER: if (k_q == '0) ph_q <= MP_FIN;
				MP_FIN: begin
					ph_q   <= MP_IDLE;
					done_q <= 1'b1;
				end
				default: ph_q <= MP_IDLE;
			endcase
		end
	end

	// Root search: largest n with n*n+n < s, one bit per cycle, MSB first.
	always_ff @(posedge clk) begin
		logic [7:0]  t;
		logic [16:0] tt;
		case (ph_q)
			MP_IDLE: begin
				if (start) begin
					for (int ch = 0; ch < 3; ch++) begin
						gx_q[ch] <= gx_c[ch];
						gy_q[ch] <= gy_c[ch];
					end
				end
			end
			MP_SQ: begin
				for (int ch = 0; ch < 3; ch++) begin
					s_q[ch] <= 21'(22'(gx_q[ch] * gx_q[ch]) + 22'(gy_q[ch] * gy_q[ch]));
					n_q[ch] <= '0;
				end
				k_q <= 3'd7;
			end
			MP_ITER: begin
				for (int ch = 0; ch < 3; ch++) begin
					t  = n_q[ch] | (8'd1 << k_q);
					tt = 17'(t * t) + 17'(t);
					if (21'(tt) < s_q[ch]) n_q[ch] <= t;
				end
				k_q <= k_q - 3'd1;
			end
			MP_FIN: begin
				res.red   <= mag_c[0];
				res.green <= mag_c[1];
				res.blue  <= mag_c[2];
			end
			default: ;
		endcase
	end

	assign done = done_q;

endmodule

[src/sobel_edge_magnitude_rgb.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb: streaming 3x3 Sobel edge magnitude on RGB pixels
// Line store, 3x3 window and magnitude unit under one control sequencer.
// ----------------------------------------------------------------------------
// Per pixel word: line store read, write-back and window shift, then, if it has a result,
// the magnitude unit and the output register; a right-edge pixel gives a second result.
// A flush word reads three columns in turn from the line store before its magnitude.
// One word at a time, waiting on the eight-step root search and output stalls; an ignored
// word is dropped. Reset (arst_n low) clears positions, frame, sequencer and output-valid
// state, and loads the size registers with their reset values.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// slave side
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [23:0]                        s_tdata,   // pixel_red, pixel_green, pixel_blue
	input  logic                               s_tuser,   // mode
	// master side
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata,   // edge_red, edge_green, edge_blue
	output logic                               m_tlast,   // last_of_run
	output logic                               m_tuser,   // end_of_frame
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sem_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sem_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH + 1);

	sem_state_t        state_q, state_d;
	logic [CW-1:0]     col_q, flush_q;
	logic [HREG_W-1:0] row_q;
	logic              frame_done_q;
	logic [WREG_W-1:0] wreg_q;
	logic [HREG_W-1:0] hreg_q;
	win_t              win_q, win_nxt, mag_win;
	pix_t              pix_q;
	logic [1:0]        fk_q;
	logic              ins_q;
	logic              pend_q, res_last_q, res_eof_q;
	logic              out_v_q;
	mag_res_t          out_q;
	logic              out_last_q, out_eof_q;

	logic [CW-1:0]     w_eff;
	logic [HREG_W-1:0] h_eff;
	logic              s_acc, cfg_acc, main_c, edge_c, out_load, mag_start, mag_done;
	logic [CW:0]       cidx;
	logic              cins;
	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr;
	logic [2*PIX_W-1:0] rd_data;
	mag_res_t          mag_res;

	// Effective frame size: registers clamped to their legal range.
	always_comb begin
		if (wreg_q == '0) begin
			w_eff = CW'(1);
		end else if (32'(wreg_q) > 32'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(wreg_q);
		end
		if (hreg_q == '0) begin
			h_eff = HREG_W'(1);
		end else if (32'(hreg_q) > 32'(HEIGHT_MAX)) begin
			h_eff = HREG_W'(HEIGHT_MAX);
		end else begin
			h_eff = hreg_q;
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// A pixel gives the output centered one row above it and one column to its left, and the row's
	// last pixel also gives the right-edge output of its own column, one row above.
	assign main_c   = (row_q != '0) && (col_q != '0);
	assign edge_c   = (row_q != '0) && ((CW+1)'(col_q) + (CW+1)'(1) == (CW+1)'(w_eff));
	assign out_load = (state_q == ST_OUT) && (!out_v_q || m_tready);

	// Flush reads the three columns around the flushed one, padded outside.
	assign cidx = (CW+1)'(flush_q) + (CW+1)'(fk_q);
	assign cins = (cidx != '0) && ((cidx - (CW+1)'(1)) < (CW+1)'(w_eff));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (s_tuser) begin
						if (frame_done_q && (flush_q < w_eff)) state_d = ST_FRD;
					end else if (!frame_done_q) begin
						state_d = ST_PRD;
					end
				end
			end
			ST_PRD: state_d = ST_PWB;
			ST_PWB: state_d = (main_c || edge_c) ? ST_MAG : ST_IDLE;
			ST_FRD: if (fk_q == 2'd3) state_d = ST_MAG;
			ST_MAG: if (mag_done) state_d = ST_OUT;
			ST_OUT: if (out_load) state_d = pend_q ? ST_MAG : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs and window update.
	always_comb begin
		win_nxt   = win_q;
		rd_en     = 1'b0;
		rd_addr   = AW'(col_q);
		wr_en     = 1'b0;
		mag_start = 1'b0;
		case (state_q)
			ST_PRD: rd_en = 1'b1;
			ST_PWB: begin
				wr_en = 1'b1;
				for (int i = 0; i < 3; i++) begin
					win_nxt[i][0] = (col_q == '0) ? '0 : win_q[i][1];
					win_nxt[i][1] = (col_q == '0) ? '0 : win_q[i][2];
				end
				win_nxt[0][2] = (row_q >= HREG_W'(2)) ? rd_data[2*PIX_W-1:PIX_W] : '0;
				win_nxt[1][2] = (row_q >= HREG_W'(1)) ? rd_data[PIX_W-1:0] : '0;
				win_nxt[2][2] = pix_q;
				mag_start = main_c || edge_c;
			end
			ST_FRD: begin
				rd_en   = (fk_q != 2'd3);
				rd_addr = AW'(cidx - (CW+1)'(1));
				if (fk_q != 2'd0) begin
					win_nxt[0][fk_q-2'd1] = (ins_q && h_eff >= HREG_W'(2)) ?
						rd_data[2*PIX_W-1:PIX_W] : '0;
					win_nxt[1][fk_q-2'd1] = ins_q ? rd_data[PIX_W-1:0] : '0;
					win_nxt[2][fk_q-2'd1] = '0;
				end
				mag_start = (fk_q == 2'd3);
			end
			ST_OUT: begin
				if (out_load && pend_q) begin
					for (int i = 0; i < 3; i++) begin
						win_nxt[i] = {PIX_W'(0), win_q[i][2], win_q[i][1]};
					end
					mag_start = 1'b1;
				end
			end
			default: ;
		endcase
		mag_win = win_nxt;
		if (state_q == ST_PWB && !main_c) begin
			for (int i = 0; i < 3; i++) begin
				mag_win[i] = {PIX_W'(0), win_nxt[i][2], win_nxt[i][1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			col_q        <= '0;
			row_q        <= '0;
			flush_q      <= '0;
			frame_done_q <= 1'b0;
			wreg_q       <= WREG_W'(WIDTH_RESET);
			hreg_q       <= HREG_W'(HEIGHT_RESET);
			fk_q         <= '0;
			pend_q       <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_tready) out_v_q <= 1'b0;
			if (out_load) out_v_q <= 1'b1;
			if (state_q == ST_IDLE) fk_q <= '0;
			if (state_q == ST_FRD) fk_q <= fk_q + 2'd1;
			if (out_load) pend_q <= 1'b0;
			if (state_q == ST_PWB) begin
				pend_q <= main_c && edge_c;
				if ((CW+1)'(col_q) + (CW+1)'(1) >= (CW+1)'(w_eff)) begin
					col_q <= '0;
					if (row_q + HREG_W'(1) >= h_eff) begin
						row_q        <= '0;
						frame_done_q <= 1'b1;
						flush_q      <= '0;
					end else begin
						row_q <= row_q + HREG_W'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (state_q == ST_FRD && fk_q == 2'd3) begin
				if ((CW+1)'(flush_q) + (CW+1)'(1) >= (CW+1)'(w_eff)) begin
					flush_q      <= '0;
					col_q        <= '0;
					row_q        <= '0;
					frame_done_q <= 1'b0;
				end else begin
					flush_q <= flush_q + CW'(1);
				end
			end
			// Any known register write restarts the frame.
			if (cfg_acc && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)) begin
				if (cfg_index == REG_WIDTH) wreg_q <= cfg_data[WREG_W-1:0];
				else hreg_q <= cfg_data;
				col_q        <= '0;
				row_q        <= '0;
				flush_q      <= '0;
				frame_done_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		win_q <= win_nxt;
		ins_q <= cins;
		if (s_acc) pix_q <= s_tdata;
		if (state_q == ST_PWB) begin
			res_last_q <= !(main_c && edge_c);
			res_eof_q  <= 1'b0;
		end
		if (state_q == ST_FRD) begin
			res_last_q <= 1'b1;
			res_eof_q  <= ((CW+1)'(flush_q) + (CW+1)'(1) == (CW+1)'(w_eff));
		end
		if (out_load) begin
			out_q      <= mag_res;
			out_last_q <= res_last_q;
			out_eof_q  <= res_eof_q;
			if (pend_q) begin
				res_last_q <= 1'b1;
				res_eof_q  <= 1'b0;
			end
		end
	end

	sem_row_mem #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_row_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (AW'(col_q)),
		.wr_data ({rd_data[PIX_W-1:0], pix_q})
	);

	sem_mag u_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mag_start),
		.win    (mag_win),
		.done   (mag_done),
		.res    (mag_res)
	);

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_q.blue, out_q.green, out_q.red};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_eof_q;

`ifndef SYNTH
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_done_q |-> (col_q < w_eff))
		else $error("column position beyond frame width");
	a_flush_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done_q |-> (flush_q < w_eff))
		else $error("flush position beyond frame width");
	a_mag_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mag_done |-> (state_q == ST_MAG))
		else $error("magnitude finished while sequencer was not waiting");
	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> !wr_en)
		else $error("line store written twice in a row");
`endif

endmodule
